/* rtl/jsu_pkg.sv */
package jsu_pkg;

   // One byte of the JSON text as it arrives.
   typedef struct packed {
      logic [7:0] in_byte;
      logic       final_req;
   } req_payload_type;

   // One decoded result.
   typedef struct packed {
      logic [7:0] out_byte;
      logic [1:0] kind;
      logic [3:0] error_code;
      logic       last;
   } rsp_payload_type;

   // Scanner modes.
   typedef enum logic [3:0] {
      MODE_IDLE   = 4'd0,
      MODE_STR    = 4'd1,
      MODE_ESC    = 4'd2,
      MODE_HEX1   = 4'd3,
      MODE_HIGH   = 4'd4,
      MODE_HIGHBS = 4'd5,
      MODE_HEX2   = 4'd6
   } scan_mode_type;

   // Result kinds.
   localparam logic [1:0] KIND_DATA   = 2'd0;
   localparam logic [1:0] KIND_CLOSED = 2'd1;
   localparam logic [1:0] KIND_ERROR  = 2'd2;

   // Error codes.
   localparam logic [3:0] ERR_NONE        = 4'd0;
   localparam logic [3:0] ERR_ESC_AT_END  = 4'd1;
   localparam logic [3:0] ERR_UNKNOWN_ESC = 4'd2;
   localparam logic [3:0] ERR_CONTROL     = 4'd3;
   localparam logic [3:0] ERR_UNCLOSED    = 4'd4;
   localparam logic [3:0] ERR_SHORT_HEX   = 4'd5;
   localparam logic [3:0] ERR_BAD_HEX     = 4'd6;
   localparam logic [3:0] ERR_LONE_LOW    = 4'd7;
   localparam logic [3:0] ERR_BAD_LOW     = 4'd8;
   localparam logic [3:0] ERR_NO_QUOTE    = 4'd9;

   // Characters of interest.
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_LOW_B  = 8'h62;
   localparam logic [7:0] CH_LOW_F  = 8'h66;
   localparam logic [7:0] CH_LOW_N  = 8'h6E;
   localparam logic [7:0] CH_LOW_R  = 8'h72;
   localparam logic [7:0] CH_LOW_T  = 8'h74;
   localparam logic [7:0] CH_LOW_U  = 8'h75;
   localparam logic [7:0] CH_SPACE  = 8'h20;

   // Control characters produced by the simple escapes.
   localparam logic [7:0] CH_BACKSPACE = 8'h08;
   localparam logic [7:0] CH_FORMFEED  = 8'h0C;
   localparam logic [7:0] CH_NEWLINE   = 8'h0A;
   localparam logic [7:0] CH_RETURN    = 8'h0D;
   localparam logic [7:0] CH_TAB       = 8'h09;

   // Depth of the response buffer, the most responses one request makes.
   localparam int RSP_DEPTH = 4;

endpackage

/* rtl/json_string_unescape_utf8_top.sv */
// JSON string unescaper. Feed the bytes of a JSON string literal, opening quote
// first, one per request; set final_req on the last byte available. Each request
// yields zero to four responses: decoded UTF-8 data bytes, a closed response at
// the closing quote, or a single error response, after which the block waits for
// a new opening quote. The last flag marks the final response of a request. A
// request's responses appear in the cycle after it is accepted and are drained
// from a four-entry response buffer, one per cycle while rsp_ready is high. A
// request that makes at most one response is taken every cycle while rsp_ready is
// high; one that makes more holds off the next request while the buffer drains,
// so only multi-byte UTF-8 output and surrogate flushes slow the input.
module json_string_unescape_utf8_top (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  jsu_pkg::req_payload_type req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output jsu_pkg::rsp_payload_type rsp_data
);
   import jsu_pkg::*;

   // Scanner state.
   scan_mode_type mode_ff, mode_in;
   logic [15:0]   acc_ff, acc_in;
   logic [1:0]    cnt_ff, cnt_in;
   logic [9:0]    high_ff, high_in;

   // Response buffer.
   rsp_payload_type slot_ff [RSP_DEPTH];
   rsp_payload_type slot_in [RSP_DEPTH];
   logic [2:0]      count_ff, count_in;

   // Decode intermediates.
   logic            accept, pop;
   logic [7:0]      b;
   logic            fin;
   logic [3:0]      err;
   logic            do_str, do_esc;
   logic            u_en;
   logic [20:0]     u_cp;
   logic            x_en;
   logic [1:0]      x_kind;
   logic [7:0]      x_byte;
   logic [3:0]      hex_val;
   logic            hex_ok;
   logic [15:0]     new_acc;
   logic [10:0]     plane;
   logic [7:0]      ub [RSP_DEPTH];
   logic [2:0]      un;
   logic [2:0]      n_res;
   rsp_payload_type list [RSP_DEPTH];

   // Handshake: take a request when the buffer empties by this edge.
   assign pop       = rsp_valid & rsp_ready;
   assign req_ready = (count_ff == 3'd0) || ((count_ff == 3'd1) && rsp_ready);
   assign accept    = req_valid & req_ready;
   assign rsp_valid = (count_ff != 3'd0);
   assign rsp_data  = slot_ff[0];

   assign b   = req_data.in_byte;
   assign fin = req_data.final_req;

   // Hex digit decode.
   always_comb begin
      hex_ok  = 1'b1;
      hex_val = 4'd0;
      if ((b >= 8'h30) && (b <= 8'h39)) begin
         hex_val = b[3:0];
      end else if (((b >= 8'h61) && (b <= 8'h66)) || ((b >= 8'h41) && (b <= 8'h46))) begin
         hex_val = 4'(b[3:0] + 4'd9);
      end else begin
         hex_ok = 1'b0;
      end
   end

   assign new_acc = {acc_ff[11:0], hex_val};
   assign plane   = 11'({1'b0, high_ff} + 11'h040);

   // Scanner next state and the code point or byte this request emits.
   always_comb begin
      mode_in = mode_ff;
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      high_in = high_ff;
      err     = ERR_NONE;
      do_str  = 1'b0;
      do_esc  = 1'b0;
      u_en    = 1'b0;
      u_cp    = 21'd0;
      x_en    = 1'b0;
      x_kind  = KIND_DATA;
      x_byte  = 8'd0;

      case (mode_ff)
         MODE_STR: begin
            do_str = 1'b1;
         end
         MODE_ESC: begin
            do_esc = 1'b1;
         end
         MODE_HEX1, MODE_HEX2: begin
            if (!hex_ok) begin
               err = ERR_BAD_HEX;
            end else begin
               acc_in = new_acc;
               if (cnt_ff != 2'd3) begin
                  cnt_in = 2'(cnt_ff + 2'd1);
               end else begin
                  cnt_in = 2'd0;
                  if (mode_ff == MODE_HEX1) begin
                     if (new_acc[15:10] == 6'b110111) begin
                        err = ERR_LONE_LOW;
                     end else if (new_acc[15:10] == 6'b110110) begin
                        high_in = new_acc[9:0];
                        mode_in = MODE_HIGH;
                     end else begin
                        u_en    = 1'b1;
                        u_cp    = {5'd0, new_acc};
                        mode_in = MODE_STR;
                     end
                  end else begin
                     // Second half of a surrogate pair joins into one code point.
                     if (new_acc[15:10] == 6'b110111) begin
                        u_en    = 1'b1;
                        u_cp    = {plane[10:0], new_acc[9:0]};
                        high_in = 10'd0;
                        mode_in = MODE_STR;
                     end else begin
                        err = ERR_BAD_LOW;
                     end
                  end
               end
            end
         end
         MODE_HIGH: begin
            if (b == CH_BSLASH) begin
               mode_in = MODE_HIGHBS;
            end else begin
               // Unpaired high surrogate is flushed as its own code point.
               u_en    = 1'b1;
               u_cp    = {5'd0, 6'b110110, high_ff};
               high_in = 10'd0;
               do_str  = 1'b1;
            end
         end
         MODE_HIGHBS: begin
            if (b == CH_LOW_U) begin
               mode_in = MODE_HEX2;
               acc_in  = 16'd0;
               cnt_in  = 2'd0;
            end else begin
               u_en    = 1'b1;
               u_cp    = {5'd0, 6'b110110, high_ff};
               high_in = 10'd0;
               do_esc  = 1'b1;
            end
         end
         default: begin
            if (b == CH_QUOTE) begin
               mode_in = MODE_STR;
            end else begin
               err = ERR_NO_QUOTE;
            end
         end
      endcase

      // A plain string byte.
      if (do_str) begin
         if (b == CH_QUOTE) begin
            x_en    = 1'b1;
            x_kind  = KIND_CLOSED;
            mode_in = MODE_IDLE;
         end else if (b == CH_BSLASH) begin
            mode_in = MODE_ESC;
         end else if (b < CH_SPACE) begin
            err = ERR_CONTROL;
         end else begin
            x_en    = 1'b1;
            x_byte  = b;
            mode_in = MODE_STR;
         end
      end

      // The character after a backslash.
      if (do_esc) begin
         mode_in = MODE_STR;
         x_en    = 1'b1;
         case (b)
            CH_QUOTE:  x_byte = CH_QUOTE;
            CH_BSLASH: x_byte = CH_BSLASH;
            CH_SLASH:  x_byte = CH_SLASH;
            CH_LOW_B:  x_byte = CH_BACKSPACE;
            CH_LOW_F:  x_byte = CH_FORMFEED;
            CH_LOW_N:  x_byte = CH_NEWLINE;
            CH_LOW_R:  x_byte = CH_RETURN;
            CH_LOW_T:  x_byte = CH_TAB;
            CH_LOW_U: begin
               x_en    = 1'b0;
               mode_in = MODE_HEX1;
               acc_in  = 16'd0;
               cnt_in  = 2'd0;
            end
            default: begin
               x_en    = 1'b0;
               mode_in = mode_ff;
               err     = ERR_UNKNOWN_ESC;
            end
         endcase
      end

      // Input ran out in the middle of a string.
      if ((err == ERR_NONE) && fin) begin
         case (mode_in)
            MODE_STR, MODE_HIGH:    err = ERR_UNCLOSED;
            MODE_ESC, MODE_HIGHBS:  err = ERR_ESC_AT_END;
            MODE_HEX1, MODE_HEX2:   err = ERR_SHORT_HEX;
            default:                err = ERR_NONE;
         endcase
      end

      // Errors and a closed string both return the scanner to its idle state.
      if ((err != ERR_NONE) || (mode_in == MODE_IDLE)) begin
         mode_in = MODE_IDLE;
         acc_in  = 16'd0;
         cnt_in  = 2'd0;
         high_in = 10'd0;
      end
   end

   // UTF-8 encoding of the emitted code point.
   always_comb begin
      for (int i = 0; i < RSP_DEPTH; i++) begin
         ub[i] = 8'd0;
      end
      un = 3'd0;
      if (u_en) begin
         if (u_cp < 21'h80) begin
            ub[0] = u_cp[7:0];
            un    = 3'd1;
         end else if (u_cp < 21'h800) begin
            ub[0] = {3'b110, u_cp[10:6]};
            ub[1] = {2'b10, u_cp[5:0]};
            un    = 3'd2;
         end else if (u_cp < 21'h10000) begin
            ub[0] = {4'b1110, u_cp[15:12]};
            ub[1] = {2'b10, u_cp[11:6]};
            ub[2] = {2'b10, u_cp[5:0]};
            un    = 3'd3;
         end else begin
            ub[0] = {5'b11110, u_cp[20:18]};
            ub[1] = {2'b10, u_cp[17:12]};
            ub[2] = {2'b10, u_cp[11:6]};
            ub[3] = {2'b10, u_cp[5:0]};
            un    = 3'd4;
         end
      end
   end

   // Assemble the responses of this request.
   always_comb begin
      for (int i = 0; i < RSP_DEPTH; i++) begin
         list[i] = '0;
      end
      if (err != ERR_NONE) begin
         list[0].kind       = KIND_ERROR;
         list[0].error_code = err;
         list[0].last       = 1'b1;
         n_res              = 3'd1;
      end else begin
         n_res = 3'(un + {2'd0, x_en});
         for (int i = 0; i < RSP_DEPTH; i++) begin
            if (3'(i) < un) begin
               list[i].out_byte = ub[i];
               list[i].kind     = KIND_DATA;
            end else if ((3'(i) == un) && x_en) begin
               list[i].out_byte = x_byte;
               list[i].kind     = x_kind;
            end
            list[i].last = (3'(i + 1) == n_res);
         end
      end
   end

   // Response buffer: load on a new request, otherwise shift out one per pop.
   always_comb begin
      count_in = count_ff;
      for (int i = 0; i < RSP_DEPTH; i++) begin
         slot_in[i] = slot_ff[i];
      end
      if (accept) begin
         count_in = n_res;
         for (int i = 0; i < RSP_DEPTH; i++) begin
            slot_in[i] = list[i];
         end
      end else if (pop) begin
         count_in = 3'(count_ff - 3'd1);
         for (int i = 0; i < RSP_DEPTH - 1; i++) begin
            slot_in[i] = slot_ff[i + 1];
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         acc_ff   <= 16'd0;
         cnt_ff   <= 2'd0;
         high_ff  <= 10'd0;
         count_ff <= 3'd0;
      end else begin
         count_ff <= count_in;
         if (accept) begin
            mode_ff <= mode_in;
            acc_ff  <= acc_in;
            cnt_ff  <= cnt_in;
            high_ff <= high_in;
         end
      end
   end

   // Response payload registers.
   always_ff @(posedge clock) begin
      for (int i = 0; i < RSP_DEPTH; i++) begin
         slot_ff[i] <= slot_in[i];
      end
   end

endmodule

/* bench/json_string_unescape_utf8_top_tb.sv */
module json_string_unescape_utf8_top_tb;
   import jsu_pkg::*;

   localparam int CYCLE_LIMIT = 200000;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_ready;
   req_payload_type req_data = '0;
   logic            rsp_valid;
   logic            rsp_ready = 1'b0;
   rsp_payload_type rsp_data;

   json_string_unescape_utf8_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // Idling knobs, in percent, and the long receiver hold-off.
   int   send_gap_pct = 0;
   int   rsp_stall_pct = 0;
   logic rsp_hold = 1'b0;

   // Run statistics.
   int cycle_count = 0;
   int bytes_sent = 0;
   int checked_count = 0;
   int mismatch_count = 0;
   int closes_seen = 0;
   int errors_seen = 0;

   // Decoder state mirrored by the predictor.
   scan_mode_type sim_mode = MODE_IDLE;
   logic [15:0]   sim_hex = '0;
   logic [1:0]    sim_digits = '0;
   logic [9:0]    sim_high = '0;
   logic [3:0]    step_err;
   rsp_payload_type step_rsp[$];

   // Decoded results still to come out of the block, oldest first.
   rsp_payload_type unescaped_q[$];

   // Text of the string being sent.
   logic [7:0] text_q[$];

   logic [7:0]  esc_chars[8] = '{CH_QUOTE, CH_BSLASH, CH_SLASH, CH_LOW_B,
                                 CH_LOW_F, CH_LOW_N, CH_LOW_R, CH_LOW_T};
   logic [15:0] cp_edges[8] = '{16'h0000, 16'h007F, 16'h0080, 16'h07FF,
                                16'h0800, 16'hD7FF, 16'hE000, 16'hFFFF};

   // Clock generation.
   initial begin
      forever #10 clock = ~clock;
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("json_string_unescape_utf8_top regression: fail");
         $finish;
      end
   end

   // Receiver: random stalls, forced low during a hold-off.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !rsp_hold && ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // ---------------------------------------------------------------- predictor

   function automatic void reset_scanner();
      sim_mode   = MODE_IDLE;
      sim_hex    = '0;
      sim_digits = '0;
      sim_high   = '0;
   endfunction

   function automatic void put_rsp(logic [7:0] b, logic [1:0] k, logic [3:0] e);
      rsp_payload_type r;
      if (step_rsp.size() < RSP_DEPTH) begin
         r.out_byte   = b;
         r.kind       = k;
         r.error_code = e;
         r.last       = 1'b0;
         step_rsp = {step_rsp, r};
      end
   endfunction

   // Encodes one code point as one to four UTF-8 bytes.
   function automatic void put_code_point(logic [20:0] cp);
      if (cp < 21'h80) begin
         put_rsp(cp[7:0], KIND_DATA, ERR_NONE);
      end else if (cp < 21'h800) begin
         put_rsp({3'b110, cp[10:6]}, KIND_DATA, ERR_NONE);
         put_rsp({2'b10, cp[5:0]}, KIND_DATA, ERR_NONE);
      end else if (cp < 21'h10000) begin
         put_rsp({4'b1110, cp[15:12]}, KIND_DATA, ERR_NONE);
         put_rsp({2'b10, cp[11:6]}, KIND_DATA, ERR_NONE);
         put_rsp({2'b10, cp[5:0]}, KIND_DATA, ERR_NONE);
      end else begin
         put_rsp({5'b11110, cp[20:18]}, KIND_DATA, ERR_NONE);
         put_rsp({2'b10, cp[17:12]}, KIND_DATA, ERR_NONE);
         put_rsp({2'b10, cp[11:6]}, KIND_DATA, ERR_NONE);
         put_rsp({2'b10, cp[5:0]}, KIND_DATA, ERR_NONE);
      end
   endfunction

   function automatic int hex_value(logic [7:0] b);
      if (b >= "0" && b <= "9") return int'(b - "0");
      if (b >= "a" && b <= "f") return int'(b - "a") + 10;
      if (b >= "A" && b <= "F") return int'(b - "A") + 10;
      return -1;
   endfunction

   // A byte inside the string body.
   function automatic void take_string_byte(logic [7:0] b);
      if (b == CH_QUOTE) begin
         put_rsp(8'h00, KIND_CLOSED, ERR_NONE);
         sim_mode = MODE_IDLE;
      end else if (b == CH_BSLASH) begin
         sim_mode = MODE_ESC;
      end else if (b < CH_SPACE) begin
         step_err = ERR_CONTROL;
      end else begin
         put_rsp(b, KIND_DATA, ERR_NONE);
         sim_mode = MODE_STR;
      end
   endfunction

   // The character after a backslash.
   function automatic void take_escape_byte(logic [7:0] b);
      logic [7:0] c;
      logic       known;
      known = 1'b1;
      c = b;
      case (b)
         CH_QUOTE, CH_BSLASH, CH_SLASH: c = b;
         CH_LOW_B: c = CH_BACKSPACE;
         CH_LOW_F: c = CH_FORMFEED;
         CH_LOW_N: c = CH_NEWLINE;
         CH_LOW_R: c = CH_RETURN;
         CH_LOW_T: c = CH_TAB;
         CH_LOW_U: begin
            sim_mode   = MODE_HEX1;
            sim_hex    = '0;
            sim_digits = '0;
            known      = 1'b0;
         end
         default: begin
            step_err = ERR_UNKNOWN_ESC;
            known    = 1'b0;
         end
      endcase
      if (known) begin
         put_rsp(c, KIND_DATA, ERR_NONE);
         sim_mode = MODE_STR;
      end
   endfunction

   // Works out the results of one accepted request and queues them.
   function automatic void unescape_byte(logic [7:0] b, logic fin);
      int digit;
      step_rsp.delete();
      step_err = ERR_NONE;
      case (sim_mode)
         MODE_STR: take_string_byte(b);
         MODE_ESC: take_escape_byte(b);
         MODE_HEX1, MODE_HEX2: begin
            digit = hex_value(b);
            if (digit < 0) begin
               step_err = ERR_BAD_HEX;
            end else begin
               sim_hex = {sim_hex[11:0], digit[3:0]};
               if (sim_digits < 2'd3) begin
                  sim_digits++;
               end else begin
                  sim_digits = '0;
                  if (sim_mode == MODE_HEX1) begin
                     if (sim_hex >= 16'hDC00 && sim_hex <= 16'hDFFF) begin
                        step_err = ERR_LONE_LOW;
                     end else if (sim_hex >= 16'hD800 && sim_hex <= 16'hDBFF) begin
                        sim_high = sim_hex[9:0];
                        sim_mode = MODE_HIGH;
                     end else begin
                        put_code_point({5'b0, sim_hex});
                        sim_mode = MODE_STR;
                     end
                  end else if (sim_hex >= 16'hDC00 && sim_hex <= 16'hDFFF) begin
                     put_code_point(21'h10000 + {1'b0, sim_high, sim_hex[9:0]});
                     sim_high = '0;
                     sim_mode = MODE_STR;
                  end else begin
                     step_err = ERR_BAD_LOW;
                  end
               end
            end
         end
         MODE_HIGH: begin
            if (b == CH_BSLASH) begin
               sim_mode = MODE_HIGHBS;
            end else begin
               // Unpaired high surrogate goes out as three bytes.
               put_code_point({5'b0, 6'b110110, sim_high});
               sim_high = '0;
               take_string_byte(b);
            end
         end
         MODE_HIGHBS: begin
            if (b == CH_LOW_U) begin
               sim_mode   = MODE_HEX2;
               sim_hex    = '0;
               sim_digits = '0;
            end else begin
               put_code_point({5'b0, 6'b110110, sim_high});
               sim_high = '0;
               take_escape_byte(b);
            end
         end
         default: begin
            if (b == CH_QUOTE) sim_mode = MODE_STR;
            else step_err = ERR_NO_QUOTE;
         end
      endcase

      // Text ending early inside a string.
      if (step_err == ERR_NONE && fin) begin
         case (sim_mode)
            MODE_STR, MODE_HIGH:    step_err = ERR_UNCLOSED;
            MODE_ESC, MODE_HIGHBS:  step_err = ERR_ESC_AT_END;
            MODE_HEX1, MODE_HEX2:   step_err = ERR_SHORT_HEX;
            default: ;
         endcase
      end

      if (step_err != ERR_NONE) begin
         step_rsp.delete();
         put_rsp(8'h00, KIND_ERROR, step_err);
         reset_scanner();
      end else if (sim_mode == MODE_IDLE) begin
         reset_scanner();
      end

      if (step_rsp.size() > 0) step_rsp[step_rsp.size() - 1].last = 1'b1;
      foreach (step_rsp[i]) unescaped_q = {unescaped_q, step_rsp[i]};
   endfunction

   // ------------------------------------------------------------------ checker

   always @(posedge clock) begin : check_rsp
      rsp_payload_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         checked_count++;
         if (unescaped_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected response: byte %h kind %0d code %0d last %0b",
                        rsp_data.out_byte, rsp_data.kind, rsp_data.error_code,
                        rsp_data.last);
         end else begin
            want = unescaped_q.pop_front();
            if (want.kind == KIND_CLOSED) closes_seen++;
            if (want.kind == KIND_ERROR) errors_seen++;
            if (rsp_data.out_byte !== want.out_byte || rsp_data.kind !== want.kind ||
                rsp_data.error_code !== want.error_code || rsp_data.last !== want.last) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display({"mismatch: got byte %h kind %0d code %0d last %0b, ",
                            "want byte %h kind %0d code %0d last %0b"},
                           rsp_data.out_byte, rsp_data.kind, rsp_data.error_code,
                           rsp_data.last, want.out_byte, want.kind, want.error_code,
                           want.last);
            end
         end
      end
   end

   // ---------------------------------------------------------------- stimulus

   // Offers one request, waits for it to be taken, then maybe idles.
   task automatic send_byte(input logic [7:0] b, input logic fin);
      req_data  <= '{in_byte: b, final_req: fin};
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      unescape_byte(b, fin);
      bytes_sent++;
      // Each idle cycle is drawn on its own, so the sender idles at the set share.
      if ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_gap_pct);
      end
   endtask

   task automatic send_text(input logic fin_last);
      for (int i = 0; i < text_q.size(); i++)
         send_byte(text_q[i], fin_last && (i == text_q.size() - 1));
      text_q.delete();
   endtask

   // Lets every queued result drain before moving on.
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (unescaped_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Appends one byte to the text being built.
   function automatic void add_byte(logic [7:0] c);
      text_q = {text_q, c};
   endfunction

   function automatic void add_str(string s);
      for (int i = 0; i < s.len(); i++) add_byte(s[i]);
   endfunction

   function automatic logic [7:0] hex_char(logic [3:0] n);
      if (n < 4'd10) return 8'h30 + n;
      return ($urandom_range(1) ? 8'h61 : 8'h41) + n - 8'd10;
   endfunction

   function automatic void add_u_escape(logic [15:0] cp);
      add_byte(CH_BSLASH);
      add_byte(CH_LOW_U);
      for (int i = 3; i >= 0; i--) add_byte(hex_char(cp[i*4 +: 4]));
   endfunction

   function automatic logic [15:0] random_bmp_point();
      case ($urandom_range(4))
         0: return 16'($urandom_range(16'h0000, 16'h007F));
         1: return 16'($urandom_range(16'h0080, 16'h07FF));
         2: return 16'($urandom_range(16'h0800, 16'hD7FF));
         3: return 16'($urandom_range(16'hE000, 16'hFFFF));
         default: return cp_edges[$urandom_range(7)];
      endcase
   endfunction

   // Builds a string literal, mostly well formed, sometimes damaged.
   task automatic build_random_string(output logic fin);
      int         n_tokens;
      int         pick;
      int         pos;
      logic [7:0] b;
      logic [15:0] cp;
      fin = ($urandom_range(4) == 0);
      add_byte(CH_QUOTE);
      n_tokens = $urandom_range(0, 10);
      repeat (n_tokens) begin
         pick = $urandom_range(99);
         if (pick < 45) begin
            do b = 8'($urandom_range(32, 255));
            while (b == CH_QUOTE || b == CH_BSLASH);
            add_byte(b);
         end else if (pick < 60) begin
            add_byte(CH_BSLASH);
            add_byte(esc_chars[$urandom_range(7)]);
         end else if (pick < 75) begin
            add_u_escape(random_bmp_point());
         end else if (pick < 86) begin
            add_u_escape({6'b110110, 10'($urandom)});
            add_u_escape({6'b110111, 10'($urandom)});
         end else if (pick < 94) begin
            // High surrogate left unpaired; the next token decides what follows.
            add_u_escape({6'b110110, 10'($urandom)});
         end else if (pick < 97) begin
            add_u_escape({6'b110111, 10'($urandom)});
         end else begin
            add_u_escape({6'b110110, 10'($urandom)});
            do cp = 16'($urandom);
            while (cp >= 16'hDC00 && cp <= 16'hDFFF);
            add_u_escape(cp);
         end
      end
      add_byte(CH_QUOTE);

      // Occasional damage to the string.
      if ($urandom_range(99) < 25) begin
         case ($urandom_range(3))
            0: begin
               pos = $urandom_range(1, text_q.size() - 1);
               text_q[pos] = 8'($urandom);
            end
            1: begin
               pos = $urandom_range(1, text_q.size() - 1);
               text_q[pos] = 8'($urandom_range(0, 31));
            end
            2: begin
               pos = $urandom_range(1, text_q.size() - 1);
               while (text_q.size() > pos) void'(text_q.pop_back());
               fin = 1'b1;
            end
            default: begin
               repeat ($urandom_range(1, 2)) text_q.push_front(8'($urandom));
            end
         endcase
      end
   endtask

   task automatic send_random_strings(input int n_bytes);
      int   target;
      logic fin;
      target = bytes_sent + n_bytes;
      while (bytes_sent < target) begin
         build_random_string(fin);
         send_text(fin);
      end
   endtask

   // ------------------------------------------------------------------- tests

   // Missing opening quote, plain bytes at both ends of the range, a simple escape.
   task automatic test_directed_text();
      add_byte(8'h00);
      send_text(1'b1);
      add_str("\"");
      add_byte(8'hFF);
      add_str(" \\n\"");
      send_text(1'b0);
      wait_for_drain();
   endtask

   // Joined pair at the top of the range, and an unpaired high surrogate.
   task automatic test_directed_surrogates();
      add_str("\"\\uDBFF\\uDFFF\"");
      send_text(1'b1);
      add_str("\"\\uD800x\"");
      send_text(1'b0);
      wait_for_drain();
   endtask

   // Lone low surrogate, bad hex digit and an unclosed string.
   task automatic test_directed_faults();
      add_str("\"\\udc00");
      send_text(1'b0);
      add_str("\"\\uG");
      send_text(1'b0);
      add_str("\"a");
      send_text(1'b1);
      wait_for_drain();
   endtask

   task automatic run_random_phase(input int gap_pct, input int stall_pct, input int n_bytes);
      send_gap_pct  = gap_pct;
      rsp_stall_pct = stall_pct;
      send_random_strings(n_bytes);
      wait_for_drain();
   endtask

   task automatic test_no_idle();
      run_random_phase(0, 0, 100);
   endtask

   task automatic test_sender_gaps();
      run_random_phase(50, 0, 100);
   endtask

   task automatic test_receiver_stalls();
      run_random_phase(0, 50, 100);
   endtask

   task automatic test_both_idle();
      run_random_phase(23, 23, 100);
   endtask

   // Receiver blocked for a long stretch while the sender keeps offering.
   task automatic test_long_hold();
      send_gap_pct  = 0;
      rsp_stall_pct = 0;
      fork
         begin
            rsp_hold <= 1'b1;
            repeat (400) @(posedge clock);
            rsp_hold <= 1'b0;
         end
         send_random_strings(60);
      join
      wait_for_drain();
   endtask

   initial begin
      reset_scanner();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_directed_text();
      test_directed_surrogates();
      test_directed_faults();
      test_no_idle();
      test_sender_gaps();
      test_receiver_stalls();
      test_both_idle();
      test_long_hold();

      repeat (10) @(posedge clock);
      $display("sent %0d bytes through directed, free-running, gapped, %s",
               bytes_sent, "stalled and held-off phases");
      $display("checked %0d responses: %0d strings closed, %0d errors, %0d mismatches",
               checked_count, closes_seen, errors_seen, mismatch_count);
      if (mismatch_count == 0 && unescaped_q.size() == 0) begin
         $display("json_string_unescape_utf8_top regression: pass");
      end else begin
         $display("json_string_unescape_utf8_top regression: fail");
      end
      $finish;
   end

endmodule

/* files.f */
rtl/jsu_pkg.sv
rtl/json_string_unescape_utf8_top.sv
bench/json_string_unescape_utf8_top_tb.sv
